// File: rtl/glyph_outline_point_decoder_macros.svh
// Assertion macros shared by the glyph outline point decoder RTL.
// No dependencies; expects i_clk and i_rst_n in the including module.
`ifndef GLYPH_OUTLINE_POINT_DECODER_MACROS_SVH
`define GLYPH_OUTLINE_POINT_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define GOPD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define GOPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/gopd_pkg.sv
// Types, constants and helper functions for the glyph outline point decoder.
// No dependencies.
package gopd_pkg;

    // Path command codes
    typedef enum logic [1:0] {
        CMD_MOVE  = 2'd0,
        CMD_LINE  = 2'd1,
        CMD_QUAD  = 2'd2,
        CMD_CLOSE = 2'd3
    } t_cmd;

    // Point flag bit positions
    localparam int FLAG_ON_CURVE = 0;
    localparam int FLAG_X_SHORT  = 1;
    localparam int FLAG_Y_SHORT  = 2;
    localparam int FLAG_X_SAME   = 4;
    localparam int FLAG_Y_SAME   = 5;

    // Result queue depth; an item writes at most two words
    localparam int RES_DEPTH   = 4;
    localparam int RES_PER_ITEM = 2;

    // One result word
    typedef struct packed {
        t_cmd               cmd;
        logic signed [16:0] end_x;
        logic signed [16:0] end_y;
        logic signed [15:0] ctrl_x;
        logic signed [15:0] ctrl_y;
        logic               last;
    } t_result;

    // Decode one axis delta from the raw data and its two flag bits
    function automatic logic [15:0] f_delta(input logic [15:0] data,
                                            input logic        is_short,
                                            input logic        same_pos);
        logic [15:0] mag;
        mag = {8'd0, data[7:0]};
        if (is_short) begin
            f_delta = same_pos ? mag : 16'(16'd0 - mag);
        end else if (same_pos) begin
            f_delta = 16'd0;
        end else begin
            f_delta = data;
        end
    endfunction

    // Build a word whose end point is a full-unit point doubled into half units
    function automatic t_result f_point(input t_cmd        cmd,
                                        input logic [15:0] px,
                                        input logic [15:0] py,
                                        input logic [15:0] cx,
                                        input logic [15:0] cy);
        t_result r;
        r.cmd    = cmd;
        r.end_x  = {px, 1'b0};
        r.end_y  = {py, 1'b0};
        r.ctrl_x = cx;
        r.ctrl_y = cy;
        r.last   = 1'b0;
        return r;
    endfunction

    // Close a contour: quadratic back to the origin if a control waits
    function automatic t_result f_close(input logic        pending,
                                        input logic [15:0] ox,
                                        input logic [15:0] oy,
                                        input logic [15:0] cx,
                                        input logic [15:0] cy);
        if (pending) begin
            f_close = f_point(CMD_QUAD, ox, oy, cx, cy);
        end else begin
            f_close = f_point(CMD_CLOSE, 16'd0, 16'd0, 16'd0, 16'd0);
        end
    endfunction

endpackage

// File: rtl/glyph_outline_point_decoder.sv
// Glyph outline point decoder: takes one outline point per cycle while o_stall
// is low and emits move, line, quadratic and close path words. Each point is
// decoded and its words are written into a four-word result queue when it is
// accepted, behind any words still queued. A point makes zero, one or two
// words; the input is taken whenever the queue has room for two, so the
// sustained rate is one point per cycle as long as the output keeps up with
// one word per cycle, and the output port (one word a cycle) sets the limit
// when points make two words.
// Depends on gopd_pkg and glyph_outline_point_decoder_macros.svh.
`include "glyph_outline_point_decoder_macros.svh"

module glyph_outline_point_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_point_flag,
    input  logic [15:0]        i_x_data,
    input  logic [15:0]        i_y_data,
    input  logic               i_contour_start,
    input  logic               i_glyph_last,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_command,
    output logic signed [16:0] o_end_x,
    output logic signed [16:0] o_end_y,
    output logic signed [15:0] o_ctrl_x,
    output logic signed [15:0] o_ctrl_y,
    output logic               o_last
);
    import gopd_pkg::*;

    localparam int PTR_W = $clog2(RES_DEPTH);
    localparam int CNT_W = $clog2(RES_DEPTH + 1);

    // Contour state
    logic [15:0] r_pos_x, r_pos_y;
    logic [15:0] r_ctrl_x, r_ctrl_y;
    logic [15:0] r_origin_x, r_origin_y;
    logic        r_curve_pending, r_contour_open;

    // Result queue
    t_result          r_mem [RES_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic        in_acc, out_acc;
    logic [15:0] n_pos_x, n_pos_y;
    logic [15:0] n_ctrl_x, n_ctrl_y;
    logic [15:0] n_origin_x, n_origin_y;
    logic        n_curve_pending;
    logic        start_eff, off_curve;
    logic        pre_v, main_v;
    t_result     pre_res, main_res, fin_res;
    t_result     slot0, slot1;
    logic [1:0]  n_words;
    logic [16:0] mid_x, mid_y;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;

    // Take a point only when two queue entries are free
    assign o_stall = (r_count > CNT_W'(RES_DEPTH - RES_PER_ITEM));
    assign o_valid = (r_count != '0);

    // Present the head of the queue
    assign o_command = r_mem[r_rd_ptr].cmd;
    assign o_end_x   = r_mem[r_rd_ptr].end_x;
    assign o_end_y   = r_mem[r_rd_ptr].end_y;
    assign o_ctrl_x  = r_mem[r_rd_ptr].ctrl_x;
    assign o_ctrl_y  = r_mem[r_rd_ptr].ctrl_y;
    assign o_last    = r_mem[r_rd_ptr].last;

    // Decode the point and build up to two result words
    always_comb begin
        n_pos_x = r_pos_x + f_delta(i_x_data, i_point_flag[FLAG_X_SHORT],
                                    i_point_flag[FLAG_X_SAME]);
        n_pos_y = r_pos_y + f_delta(i_y_data, i_point_flag[FLAG_Y_SHORT],
                                    i_point_flag[FLAG_Y_SAME]);
        start_eff = i_contour_start || !r_contour_open;
        off_curve = !i_point_flag[FLAG_ON_CURVE];
        mid_x = {r_ctrl_x[15], r_ctrl_x} + {n_pos_x[15], n_pos_x};
        mid_y = {r_ctrl_y[15], r_ctrl_y} + {n_pos_y[15], n_pos_y};

        // Close of the previous contour ahead of a new one
        pre_v   = start_eff && r_contour_open;
        pre_res = f_close(r_curve_pending, r_origin_x, r_origin_y, r_ctrl_x, r_ctrl_y);

        n_ctrl_x        = r_ctrl_x;
        n_ctrl_y        = r_ctrl_y;
        n_origin_x      = r_origin_x;
        n_origin_y      = r_origin_y;
        n_curve_pending = r_curve_pending;
        main_v          = 1'b0;
        main_res        = f_point(CMD_LINE, n_pos_x, n_pos_y, 16'd0, 16'd0);

        if (start_eff) begin
            main_v          = !i_glyph_last;
            main_res        = f_point(CMD_MOVE, n_pos_x, n_pos_y, 16'd0, 16'd0);
            n_origin_x      = n_pos_x;
            n_origin_y      = n_pos_y;
            n_curve_pending = 1'b0;
        end else if (off_curve) begin
            // Two off-curve points in a row: curve to the implied midpoint
            main_v          = r_curve_pending;
            main_res.cmd    = CMD_QUAD;
            main_res.end_x  = mid_x;
            main_res.end_y  = mid_y;
            main_res.ctrl_x = r_ctrl_x;
            main_res.ctrl_y = r_ctrl_y;
            n_ctrl_x        = n_pos_x;
            n_ctrl_y        = n_pos_y;
            n_curve_pending = 1'b1;
        end else if (r_curve_pending) begin
            main_v          = 1'b1;
            main_res        = f_point(CMD_QUAD, n_pos_x, n_pos_y, r_ctrl_x, r_ctrl_y);
            n_curve_pending = 1'b0;
        end else begin
            main_v = 1'b1;
        end

        // Final close of the glyph uses the state after this point
        fin_res = f_close(n_curve_pending, n_origin_x, n_origin_y, n_ctrl_x, n_ctrl_y);

        // Pack the words in order; at most two are ever present
        if (pre_v) begin
            slot0 = pre_res;
            slot1 = main_v ? main_res : fin_res;
        end else if (main_v) begin
            slot0 = main_res;
            slot1 = fin_res;
        end else begin
            slot0 = fin_res;
            slot1 = fin_res;
        end
        n_words = 2'(pre_v) + 2'(main_v) + 2'(i_glyph_last);
        slot0.last = (n_words == 2'd1);
        slot1.last = 1'b1;
    end

    // Hold contour state and advance queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x         <= '0;
            r_pos_y         <= '0;
            r_ctrl_x        <= '0;
            r_ctrl_y        <= '0;
            r_origin_x      <= '0;
            r_origin_y      <= '0;
            r_curve_pending <= 1'b0;
            r_contour_open  <= 1'b0;
            r_wr_ptr        <= '0;
            r_rd_ptr        <= '0;
            r_count         <= '0;
        end else begin
            if (in_acc) begin
                if (i_glyph_last) begin
                    r_pos_x         <= '0;
                    r_pos_y         <= '0;
                    r_ctrl_x        <= '0;
                    r_ctrl_y        <= '0;
                    r_origin_x      <= '0;
                    r_origin_y      <= '0;
                    r_curve_pending <= 1'b0;
                    r_contour_open  <= 1'b0;
                end else begin
                    r_pos_x         <= n_pos_x;
                    r_pos_y         <= n_pos_y;
                    r_ctrl_x        <= n_ctrl_x;
                    r_ctrl_y        <= n_ctrl_y;
                    r_origin_x      <= n_origin_x;
                    r_origin_y      <= n_origin_y;
                    r_curve_pending <= n_curve_pending;
                    r_contour_open  <= 1'b1;
                end
                r_wr_ptr <= r_wr_ptr + PTR_W'(n_words);
            end
            if (out_acc) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + (in_acc ? CNT_W'(n_words) : CNT_W'(0))
                               - (out_acc ? CNT_W'(1) : CNT_W'(0));
        end
    end

    // Write result words into free queue entries
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            if (n_words != 2'd0) begin
                r_mem[r_wr_ptr] <= slot0;
            end
            if (n_words == 2'd2) begin
                r_mem[r_wr_ptr + PTR_W'(1)] <= slot1;
            end
        end
    end

    `GOPD_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_W'(RES_DEPTH),
        "result queue count exceeds depth")
    `GOPD_ASSERT_NOW(a_room_on_accept, in_acc,
        r_count <= CNT_W'(RES_DEPTH - RES_PER_ITEM),
        "point accepted without room for two words")
    `GOPD_ASSERT_NOW(a_ptr_gap, 1'b1,
        (r_count == CNT_W'(RES_DEPTH)) || (r_wr_ptr - r_rd_ptr == PTR_W'(r_count)),
        "queue pointers disagree with count")
    `GOPD_ASSERT_NEXT(a_glyph_reset, in_acc && i_glyph_last,
        !r_contour_open && !r_curve_pending && r_pos_x == 16'd0 && r_pos_y == 16'd0,
        "state not cleared after final point of glyph")
endmodule
